/* sv/longest_prefix_route_lookup_unit_defines.svh */
// assertion macros shared by the route lookup rtl
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_UNIT_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LPR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lpr check failed");

// next-cycle implication, checked outside reset
`define LPR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lpr check failed");

`endif

/* sv/lpr_pkg.sv */
// types, constants and helper functions of the route lookup unit
package lpr_pkg;

    localparam int ADDR_W          = 32;
    localparam int SLOT_FIELD_W    = 4;
    localparam int PORT_FIELD_W    = 2;
    localparam int LEN_W           = 6;
    localparam int TABLE_SLOTS_DEF = 16;
    localparam int PORT_COUNT_DEF  = 4;

    // transaction kinds
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // table write broadcast to every cell
    typedef struct packed {
        logic                    en;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [ADDR_W-1:0]       prefix;
        logic [ADDR_W-1:0]       run;
        logic [ADDR_W-1:0]       gateway;
        logic [PORT_FIELD_W-1:0] port;
        logic                    enable;
    } t_lpr_wr;

    // lookup token walking the cell chain with the best route so far
    typedef struct packed {
        logic                    active;
        logic [ADDR_W-1:0]       addr;
        logic [ADDR_W-1:0]       best_run;
        logic [ADDR_W-1:0]       best_gw;
        logic [PORT_FIELD_W-1:0] best_port;
    } t_lpr_tok;

    // leading run of ones of a mask, everything below the first zero cleared
    function automatic logic [ADDR_W-1:0] lpr_run_mask(input logic [ADDR_W-1:0] mask);
        logic [ADDR_W-1:0] run;
        logic [ADDR_W-1:0] low;
        run = '0;
        for (int b = 0; b < ADDR_W; b++) begin
            low    = (ADDR_W'(1) << b) - ADDR_W'(1);
            run[b] = &(mask | low);
        end
        return run;
    endfunction

    // length of a leading-ones run, binary search over the thermometer code
    function automatic logic [LEN_W-1:0] lpr_run_len(input logic [ADDR_W-1:0] run);
        logic [LEN_W-1:0] v;
        logic [LEN_W-1:0] c;
        v = '0;
        c = '0;
        if (run[0]) begin
            v = LEN_W'(ADDR_W);
        end else begin
            for (int s = LEN_W - 2; s >= 0; s--) begin
                c = v | (LEN_W'(1) << s);
                if (run[ADDR_W - int'(c)]) begin
                    v = c;
                end
            end
        end
        return v;
    endfunction

endpackage

/* sv/lpr_if.sv */
// request and response channel interfaces of the route lookup unit
interface lpr_req_if import lpr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [SLOT_FIELD_W-1:0] entry_slot;
    logic [ADDR_W-1:0]       route_prefix;
    logic [ADDR_W-1:0]       route_mask;
    logic [ADDR_W-1:0]       route_gateway;
    logic [PORT_FIELD_W-1:0] route_port;
    logic                    route_enable;
    logic [ADDR_W-1:0]       dest_addr;

    modport source (
        output valid, func, entry_slot, route_prefix, route_mask, route_gateway,
               route_port, route_enable, dest_addr,
        input  ready
    );
    modport sink (
        input  valid, func, entry_slot, route_prefix, route_mask, route_gateway,
               route_port, route_enable, dest_addr,
        output ready
    );
endinterface

interface lpr_rsp_if import lpr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] match_slot;
    logic [LEN_W-1:0]        match_length;
    logic [ADDR_W-1:0]       next_hop;
    logic [PORT_FIELD_W-1:0] out_port;

    modport source (
        output valid, hit, match_slot, match_length, next_hop, out_port,
        input  ready
    );
    modport sink (
        input  valid, hit, match_slot, match_length, next_hop, out_port,
        output ready
    );
endinterface

/* sv/lpr_cell.sv */
// one table slot: stored route plus the compare stage of the lookup chain
module lpr_cell import lpr_pkg::*; #(
    parameter int SLOT_W   = 4,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lpr_wr           i_wr,
    input  logic              i_adv,
    input  t_lpr_tok          i_tok,
    input  logic [SLOT_W-1:0] i_slot,
    output t_lpr_tok          o_tok,
    output logic [SLOT_W-1:0] o_slot
);

    localparam int CMP_W = SLOT_W + SLOT_FIELD_W;

    logic                    r_valid;
    logic [ADDR_W-1:0]       r_prefix;
    logic [ADDR_W-1:0]       r_run;
    logic [ADDR_W-1:0]       r_gateway;
    logic [PORT_FIELD_W-1:0] r_port;
    t_lpr_tok                r_tok;
    logic [SLOT_W-1:0]       r_slot;

    logic                    w_sel;
    logic                    w_better;
    t_lpr_tok                n_tok;
    logic [SLOT_W-1:0]       n_slot;

    // write decode for this slot
    assign w_sel = i_wr.en && (CMP_W'(i_wr.slot) == CMP_W'(CELL_IDX));

    // strictly longer match replaces the best, so ties stay with the lower slot
    assign w_better = r_valid
                   && (((i_tok.addr ^ r_prefix) & r_run) == '0)
                   && (r_run > i_tok.best_run);

    always_comb begin
        n_tok  = i_tok;
        n_slot = i_slot;
        if (w_better) begin
            n_tok.best_run  = r_run;
            n_tok.best_gw   = r_gateway;
            n_tok.best_port = r_port;
            n_slot          = SLOT_W'(CELL_IDX);
        end
    end

    // route storage and chain stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            if (w_sel) begin
                r_valid <= i_wr.enable;
            end
            if (i_adv) begin
                r_tok.active <= n_tok.active;
            end
        end
        if (w_sel) begin
            r_prefix  <= i_wr.prefix;
            r_run     <= i_wr.run;
            r_gateway <= i_wr.gateway;
            r_port    <= i_wr.port;
        end
        if (i_adv) begin
            r_tok.addr      <= n_tok.addr;
            r_tok.best_run  <= n_tok.best_run;
            r_tok.best_gw   <= n_tok.best_gw;
            r_tok.best_port <= n_tok.best_port;
            r_slot          <= n_slot;
        end
    end

    assign o_tok  = r_tok;
    assign o_slot = r_slot;

endmodule

/* sv/longest_prefix_route_lookup_unit.sv */
// top level of the longest prefix route lookup unit
//
//  channel  dir  handshake          carries
//  i_req    in   valid / ready      table write or destination lookup
//  o_rsp    out  valid / ready      lookup result, none for a write
//
// a write updates the addressed slot when accepted; a lookup passes one
// register per cell of the compare chain and then the report stage.
// one lookup is in the chain at a time; i_req.ready stays low until it
// reaches the output register, which may still hold an earlier result.
// a stalled output register freezes the chain until the result is taken.
// reset (synchronous, active low) clears slot valid bits and all handshakes.
`include "longest_prefix_route_lookup_unit_defines.svh"

module longest_prefix_route_lookup_unit import lpr_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int PORT_COUNT  = PORT_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpr_req_if.sink   i_req,
    lpr_rsp_if.source o_rsp
);

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = 9;
    localparam int PCNT_W = 8;

    logic                    r_busy;
    logic                    r_out_valid;
    logic                    r_hit;
    logic [SLOT_FIELD_W-1:0] r_match_slot;
    logic [LEN_W-1:0]        r_match_length;
    logic [ADDR_W-1:0]       r_next_hop;
    logic [PORT_FIELD_W-1:0] r_out_port;

    logic                    w_acc;
    logic                    w_lookup;
    logic                    w_out_free;
    logic                    w_adv;
    logic                    w_done;
    t_lpr_wr                 w_wr;
    t_lpr_tok                w_tok  [TABLE_SLOTS+1];
    logic [SLOT_W-1:0]       w_slot [TABLE_SLOTS+1];
    logic [TABLE_SLOTS-1:0]  w_act;

    // input transaction decode
    assign i_req.ready = !r_busy;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_lookup    = w_acc && (i_req.func == FUNC_LOOKUP);

    // write broadcast, out-of-range slot or port is dropped
    always_comb begin
        w_wr.en      = w_acc && (i_req.func == FUNC_WRITE)
                    && (CNT_W'(i_req.entry_slot) < CNT_W'(TABLE_SLOTS))
                    && (PCNT_W'(i_req.route_port) < PCNT_W'(PORT_COUNT));
        w_wr.slot    = i_req.entry_slot;
        w_wr.prefix  = i_req.route_prefix;
        w_wr.run     = lpr_run_mask(i_req.route_mask);
        w_wr.gateway = i_req.route_gateway;
        w_wr.port    = i_req.route_port;
        w_wr.enable  = i_req.route_enable;
    end

    // token entering the chain, best route starts empty
    always_comb begin
        w_tok[0].active    = w_lookup;
        w_tok[0].addr      = i_req.dest_addr;
        w_tok[0].best_run  = '0;
        w_tok[0].best_gw   = '0;
        w_tok[0].best_port = '0;
        w_slot[0]          = '0;
    end

    // chain advances unless a finished token has nowhere to go
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_done     = w_tok[TABLE_SLOTS].active && w_out_free;
    assign w_adv      = !w_tok[TABLE_SLOTS].active || w_out_free;

    // row of slot cells
    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        lpr_cell #(
            .SLOT_W   (SLOT_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .i_slot  (w_slot[g]),
            .o_tok   (w_tok[g+1]),
            .o_slot  (w_slot[g+1])
        );
        assign w_act[g] = w_tok[g+1].active;
    end

    // busy flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_lookup) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_done) begin
            r_hit          <= (w_tok[TABLE_SLOTS].best_run != '0);
            r_match_slot   <= SLOT_FIELD_W'(w_slot[TABLE_SLOTS]);
            r_match_length <= lpr_run_len(w_tok[TABLE_SLOTS].best_run);
            r_next_hop     <= w_tok[TABLE_SLOTS].best_gw;
            r_out_port     <= w_tok[TABLE_SLOTS].best_port;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.hit          = r_hit;
    assign o_rsp.match_slot   = r_match_slot;
    assign o_rsp.match_length = r_match_length;
    assign o_rsp.next_hop     = r_next_hop;
    assign o_rsp.out_port     = r_out_port;

    // checks on chain occupancy and result coding
    `LPR_ASSERT_IMP(a_single_token, i_clk, i_rst_n, 1'b1, $countones(w_act) <= 1)
    `LPR_ASSERT_IMP(a_busy_covers_chain, i_clk, i_rst_n, (w_act != '0), r_busy)
    `LPR_ASSERT_NXT(a_done_gives_result, i_clk, i_rst_n, w_done, o_rsp.valid)
    `LPR_ASSERT_IMP(a_miss_is_zero, i_clk, i_rst_n, (o_rsp.valid && !o_rsp.hit),
        (o_rsp.match_length == '0) && (o_rsp.next_hop == '0) && (o_rsp.out_port == '0))
    `LPR_ASSERT_IMP(a_hit_has_length, i_clk, i_rst_n, (o_rsp.valid && o_rsp.hit),
        (o_rsp.match_length != '0))

endmodule
